>>> sv/ksql_pkg.sv
`timescale 1ns / 1ps

package ksql_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int ID_W       = 8;
	localparam int QTY_W      = 32;
	localparam int POS_W      = 4;

	typedef logic [ID_W-1:0]  id_t;
	typedef logic [QTY_W-1:0] qty_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [POS_W-1:0] pos_t;

endpackage

>>> sv/keyed_sorted_quantity_list.sv
`timescale 1ns / 1ps

// Sorted list of up to LIST_DEPTH (venue id, quantity) entries, largest quantity
// first. An item is taken when start is high and busy is low; busy then stays
// high until the item's run of LIST_DEPTH results has been issued, one rank per
// cycle, each marked by strobe for a single cycle with last on the final rank.
// The receiver cannot stall, so it must take every strobed result. The list is
// scanned one entry per cycle by a single id/quantity comparator: a scan for the
// id, a step to close the gap of an entry taken out if the id was found, a scan
// for the insertion rank unless the quantity is zero or a full list rejects the
// item, then the LIST_DEPTH output results. A delete on an empty list holds busy
// the shortest time and moving the id held at the lowest rank of a full list the
// longest; the last result appears in the same cycle that busy falls.
module keyed_sorted_quantity_list (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  ksql_pkg::id_t          venue_id,
	input  ksql_pkg::qty_t         quantity,
	output logic                   strobe,
	output ksql_pkg::pos_t         position,
	output ksql_pkg::id_t          entry_id,
	output ksql_pkg::qty_t         entry_quantity,
	output logic                   occupied,
	output logic                   rejected,
	output logic                   last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_DROP,
		ST_SEEK,
		ST_EMIT
	} state_t;

	state_t          state_q;
	ksql_pkg::id_t   id_store_q  [ksql_pkg::LIST_DEPTH];
	ksql_pkg::qty_t  qty_store_q [ksql_pkg::LIST_DEPTH];
	ksql_pkg::cnt_t  count_q;
	ksql_pkg::cnt_t  idx_q;
	ksql_pkg::pos_t  pos_q;
	ksql_pkg::id_t   in_id_q;
	ksql_pkg::qty_t  in_qty_q;
	logic            rej_q;

	logic            strobe_q;
	ksql_pkg::pos_t  position_q;
	ksql_pkg::id_t   entry_id_q;
	ksql_pkg::qty_t  entry_qty_q;
	logic            occupied_q;
	logic            rejected_q;
	logic            last_q;

	ksql_pkg::idx_t  rd_idx;
	logic            at_end;
	logic            id_hit;
	logic            qty_ge;
	logic            do_drop;
	logic            do_place;

	function automatic ksql_pkg::cnt_t CNT_EXT(input int v);
		CNT_EXT = ksql_pkg::cnt_t'(v);
	endfunction

	assign rd_idx = idx_q[ksql_pkg::IDX_W-1:0];
	assign at_end = (idx_q == count_q);
	assign id_hit = (id_store_q[rd_idx] == in_id_q);
	assign qty_ge = (in_qty_q >= qty_store_q[rd_idx]);

	assign do_drop  = (state_q == ST_DROP);
	assign do_place = (state_q == ST_SEEK) && (at_end || qty_ge);

	assign busy           = (state_q != ST_IDLE);
	assign strobe         = strobe_q;
	assign position       = position_q;
	assign entry_id       = entry_id_q;
	assign entry_quantity = entry_qty_q;
	assign occupied       = occupied_q;
	assign rejected       = rejected_q;
	assign last           = last_q;

	// list storage; ranks at or past count_q are never shown or compared
	always_ff @(posedge clk) begin
		if (do_drop) begin
			for (int k = 0; k < ksql_pkg::LIST_DEPTH - 1; k++) begin
				if (CNT_EXT(k) >= idx_q && CNT_EXT(k + 1) < count_q) begin
					id_store_q[k]  <= id_store_q[k + 1];
					qty_store_q[k] <= qty_store_q[k + 1];
				end
			end
		end else if (do_place) begin
			for (int k = 1; k < ksql_pkg::LIST_DEPTH; k++) begin
				if (CNT_EXT(k) > idx_q && CNT_EXT(k) <= count_q) begin
					id_store_q[k]  <= id_store_q[k - 1];
					qty_store_q[k] <= qty_store_q[k - 1];
				end
			end
			id_store_q[rd_idx]  <= in_id_q;
			qty_store_q[rd_idx] <= in_qty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
			rej_q      <= 1'b0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						in_id_q  <= venue_id;
						in_qty_q <= quantity;
						idx_q    <= '0;
						rej_q    <= 1'b0;
						state_q  <= ST_FIND;
					end
				end
				ST_FIND: begin
					priority if (at_end) begin
						idx_q <= '0;
						pos_q <= '0;
						priority if (in_qty_q == '0) begin
							state_q <= ST_EMIT;
						end else if (count_q == ksql_pkg::cnt_t'(ksql_pkg::LIST_DEPTH)) begin
							rej_q   <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SEEK;
						end
					end else if (id_hit) begin
						state_q <= ST_DROP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DROP: begin
					count_q <= count_q - 1'b1;
					idx_q   <= '0;
					pos_q   <= '0;
					state_q <= (in_qty_q == '0) ? ST_EMIT : ST_SEEK;
				end
				ST_SEEK: begin
					if (do_place) begin
						count_q <= count_q + 1'b1;
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					strobe_q   <= 1'b1;
					position_q <= pos_q;
					occupied_q <= (idx_q < count_q);
					entry_id_q <= (idx_q < count_q) ? id_store_q[rd_idx] : '0;
					entry_qty_q <= (idx_q < count_q) ? qty_store_q[rd_idx] : '0;
					rejected_q <= rej_q;
					pos_q      <= pos_q + 1'b1;
					if (idx_q == ksql_pkg::cnt_t'(ksql_pkg::LIST_DEPTH - 1)) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ksql_pkg::cnt_t'(ksql_pkg::LIST_DEPTH))
		else $error("entry count beyond list depth");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("busy dropped without final rank");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rejected) |-> (count_q == ksql_pkg::cnt_t'(ksql_pkg::LIST_DEPTH)))
		else $error("rejected while list had room");

	a_occ_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && occupied) |-> (entry_quantity != '0))
		else $error("occupied rank holds zero quantity");

	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("result issued while idle");
`endif

endmodule
